// File: rtl/vnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared types and constants of the fractal value-noise height pipeline.
// ----------------------------------------------------------------------------
package vnf_pkg;

   localparam int unsigned DEF_MAX_OCTAVES = 8;
   localparam int unsigned COUNT_W         = 5;
   localparam int unsigned SUM_W           = 61;
   localparam int unsigned NORM_W          = 37;
   localparam int unsigned QUOT_W          = 24;
   localparam int unsigned DIV_W           = SUM_W + QUOT_W;

   localparam logic [31:0] OCT_SEED_STEP = 32'd1315423911;
   localparam logic [31:0] HASH_MUL_X    = 32'h9E3779B1;
   localparam logic [31:0] HASH_MUL_Z    = 32'h85EBCA6B;
   localparam logic [23:0] UNIT_MAX      = 24'hFFFFFF;
   localparam logic [31:0] ONE_Q16       = 32'h0001_0000;

   typedef enum logic [2:0] {
      REG_NOISE_SEED   = 3'd0,
      REG_OCTAVE_COUNT = 3'd1,
      REG_PERSISTENCE  = 3'd2,
      REG_LACUNARITY   = 3'd3,
      REG_HEIGHT_SCALE = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       x;
      logic [31:0]       z;
      logic [31:0]       freq;
      logic [31:0]       amp;
      logic [SUM_W-1:0]  sum;
      logic [NORM_W-1:0] norm;
   } carry_type;

endpackage

// File: rtl/vnf_octave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnf_octave
// One octave of value noise in six register stages: scaling, lattice hash,
// smoothstep, bilinear blend and weighted accumulation.
// ----------------------------------------------------------------------------
module vnf_octave #(
   parameter int unsigned OCT_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [31:0]                        seed_base,
   input  logic [15:0]                        lacunarity,
   input  logic [15:0]                        persistence,
   input  logic [vnf_pkg::COUNT_W-1:0]        count,
   input  vnf_pkg::carry_type                 carry_in,
   output vnf_pkg::carry_type                 carry_out
);

   localparam logic [63:0] SEED_OFF = 64'(OCT_INDEX) * 64'(vnf_pkg::OCT_SEED_STEP);

   function automatic logic [23:0] mix_unit(input logic [31:0] v);
      logic [31:0] t;
      begin
         t = v ^ (v << 13);
         t = t ^ (t >> 17);
         t = t ^ (t << 5);
         return t[23:0];
      end
   endfunction

   function automatic logic [23:0] lerp_unit(input logic [23:0] p, input logic [23:0] q,
                                              input logic [16:0] w);
      logic signed [24:0] diff;
      logic signed [42:0] prod;
      logic signed [42:0] res;
      begin
         diff = $signed({1'b0, q}) - $signed({1'b0, p});
         prod = 43'(diff * $signed({1'b0, w}));
         res  = 43'($signed({1'b0, p})) + (prod >>> 16);
         return res[23:0];
      end
   endfunction

   logic [31:0] seed;
   assign seed = seed_base + SEED_OFF[31:0];

   // Stage 1: scaled coordinates.
   vnf_pkg::carry_type c1_ff;
   logic [63:0] px_ff, pz_ff, px_in, pz_in;

   assign px_in = 64'($signed(carry_in.x) * $signed({1'b0, carry_in.freq}));
   assign pz_in = 64'($signed(carry_in.z) * $signed({1'b0, carry_in.freq}));

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      pz_ff <= pz_in;
      if (reset) begin
         c1_ff.valid <= 1'b0;
      end else begin
         c1_ff <= carry_in;
      end
   end

   // Stage 2: lattice products, fraction squares, next frequency.
   vnf_pkg::carry_type c2_ff, c2_in;
   logic [31:0] hx0_ff, hx1_ff, hz0_ff, hz1_ff;
   logic [31:0] hx0_in, hz0_in;
   logic [15:0] fx_ff, fz_ff;
   logic [31:0] fx2_ff, fz2_ff;
   logic [47:0] fprod;

   assign hx0_in = px_ff[63:32] * vnf_pkg::HASH_MUL_X;
   assign hz0_in = pz_ff[63:32] * vnf_pkg::HASH_MUL_Z;
   assign fprod  = 48'(c1_ff.freq) * 48'(lacunarity);

   always_comb begin
      c2_in = c1_ff;
      c2_in.freq = (|fprod[47:44]) ? 32'hFFFF_FFFF : fprod[43:12];
   end

   always_ff @(posedge clock) begin
      hx0_ff <= hx0_in;
      hx1_ff <= hx0_in + vnf_pkg::HASH_MUL_X;
      hz0_ff <= hz0_in;
      hz1_ff <= hz0_in + vnf_pkg::HASH_MUL_Z;
      fx_ff  <= px_ff[31:16];
      fz_ff  <= pz_ff[31:16];
      fx2_ff <= {16'd0, px_ff[31:16]} * {16'd0, px_ff[31:16]};
      fz2_ff <= {16'd0, pz_ff[31:16]} * {16'd0, pz_ff[31:16]};
      if (reset) begin
         c2_ff.valid <= 1'b0;
      end else begin
         c2_ff <= c2_in;
      end
   end

   // Stage 3: corner hashes and smoothstep weights.
   vnf_pkg::carry_type c3_ff;
   logic [23:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [16:0] wx_ff, wz_ff;
   logic [17:0] tx, tz;
   logic [49:0] wxp, wzp;

   assign tx  = 18'd196608 - {1'b0, fx_ff, 1'b0};
   assign tz  = 18'd196608 - {1'b0, fz_ff, 1'b0};
   assign wxp = 50'(fx2_ff) * 50'(tx);
   assign wzp = 50'(fz2_ff) * 50'(tz);

   always_ff @(posedge clock) begin
      ca_ff <= mix_unit(hx0_ff ^ hz0_ff ^ seed);
      cb_ff <= mix_unit(hx1_ff ^ hz0_ff ^ seed);
      cc_ff <= mix_unit(hx0_ff ^ hz1_ff ^ seed);
      cd_ff <= mix_unit(hx1_ff ^ hz1_ff ^ seed);
      wx_ff <= wxp[48:32];
      wz_ff <= wzp[48:32];
      if (reset) begin
         c3_ff.valid <= 1'b0;
      end else begin
         c3_ff <= c2_ff;
      end
   end

   // Stage 4: blend along x.
   vnf_pkg::carry_type c4_ff;
   logic [23:0] ab_ff, cdl_ff;
   logic [16:0] wz4_ff;

   always_ff @(posedge clock) begin
      ab_ff  <= lerp_unit(ca_ff, cb_ff, wx_ff);
      cdl_ff <= lerp_unit(cc_ff, cd_ff, wx_ff);
      wz4_ff <= wz_ff;
      if (reset) begin
         c4_ff.valid <= 1'b0;
      end else begin
         c4_ff <= c3_ff;
      end
   end

   // Stage 5: blend along z.
   vnf_pkg::carry_type c5_ff;
   logic [23:0] n_ff;

   always_ff @(posedge clock) begin
      n_ff  <= lerp_unit(ab_ff, cdl_ff, wz4_ff);
      if (reset) begin
         c5_ff.valid <= 1'b0;
      end else begin
         c5_ff <= c4_ff;
      end
   end

   // Stage 6: weighted accumulation and next amplitude.
   vnf_pkg::carry_type c6_ff, c6_in;
   logic [55:0] wsum;
   logic [47:0] aprod;
   logic        active;

   assign active = vnf_pkg::COUNT_W'(OCT_INDEX) < count;
   assign wsum   = 56'(c5_ff.amp) * 56'(n_ff);
   assign aprod  = 48'(c5_ff.amp) * 48'(persistence);

   always_comb begin
      c6_in = c5_ff;
      c6_in.amp = (|aprod[47:44]) ? 32'hFFFF_FFFF : aprod[43:12];
      if (active) begin
         c6_in.sum  = c5_ff.sum + vnf_pkg::SUM_W'(wsum);
         c6_in.norm = c5_ff.norm + vnf_pkg::NORM_W'(c5_ff.amp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c6_ff.valid <= 1'b0;
      end else begin
         c6_ff <= c6_in;
      end
   end

   assign carry_out = c6_ff;

endmodule

// File: rtl/vnf_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnf_divide
// Pipelined restoring divider: one quotient bit per stage, normalized value.
// ----------------------------------------------------------------------------
module vnf_divide (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [vnf_pkg::SUM_W-1:0]         in_sum,
   input  logic [vnf_pkg::NORM_W-1:0]        in_norm,
   output logic                              out_valid,
   output logic [vnf_pkg::QUOT_W-1:0]        out_quot
);

   localparam int unsigned QW = vnf_pkg::QUOT_W;
   localparam int unsigned DW = vnf_pkg::DIV_W;

   logic                          vld_ff  [0:QW];
   logic                          zero_ff [0:QW];
   logic                          cap_ff  [0:QW];
   logic [vnf_pkg::SUM_W-1:0]     rem_ff  [0:QW];
   logic [vnf_pkg::NORM_W-1:0]    nrm_ff  [0:QW];
   logic [QW-1:0]                 quo_ff  [0:QW];

   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_norm == '0);
      cap_ff[0]  <= DW'(in_sum) >= (DW'(in_norm) << QW);
      rem_ff[0]  <= in_sum;
      nrm_ff[0]  <= in_norm;
      quo_ff[0]  <= '0;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_bit
      logic [DW-1:0] shifted;
      logic [DW-1:0] diff;
      logic          ge;

      assign shifted = DW'(nrm_ff[k]) << (QW - 1 - k);
      assign ge      = DW'(rem_ff[k]) >= shifted;
      assign diff    = DW'(rem_ff[k]) - shifted;

      always_ff @(posedge clock) begin
         zero_ff[k+1] <= zero_ff[k];
         cap_ff[k+1]  <= cap_ff[k];
         nrm_ff[k+1]  <= nrm_ff[k];
         rem_ff[k+1]  <= ge ? diff[vnf_pkg::SUM_W-1:0] : rem_ff[k];
         quo_ff[k+1]  <= quo_ff[k] | (QW'(ge) << (QW - 1 - k));
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quot  = zero_ff[QW] ? '0 : (cap_ff[QW] ? vnf_pkg::UNIT_MAX : quo_ff[QW]);

endmodule

// File: rtl/value_noise_fbm_height.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_fbm_height
// Fractal value-noise height for one Q16.16 point per cycle.
//
// A transfer on the request side happens at a clock edge with start high;
// busy is always low, so a new point may enter in every cycle. Each point
// runs through MAX_OCTAVES octave units of six stages each, a divider of
// 25 stages and two stages of height scaling. The result appears on the
// rsp_ ports for one cycle with rsp_valid high. Throughput is one point
// per cycle, set by the fully pipelined octave units and divider.
// The receiver cannot hold results off; every result must be taken in its
// cycle. Reset clears all valid bits, so items in flight are dropped, and
// restores the registers to their defaults. The csr_ port writes one
// register per cycle; it is meant to be written only while no point is in
// flight.
// ----------------------------------------------------------------------------
module value_noise_fbm_height #(
   parameter int unsigned MAX_OCTAVES = vnf_pkg::DEF_MAX_OCTAVES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_noise_x,
   input  logic signed [31:0] req_noise_z,
   output logic               rsp_valid,
   output logic [23:0]        rsp_unit_value,
   output logic signed [31:0] rsp_height,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [31:0] seed_ff;
   logic [3:0]  count_ff;
   logic [15:0] pers_ff;
   logic [15:0] lac_ff;
   logic [31:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd0;
         count_ff <= 4'd4;
         pers_ff  <= 16'd2048;
         lac_ff   <= 16'd8192;
         scale_ff <= 32'd65536;
      end else if (csr_we) begin
         unique case (vnf_pkg::reg_index_type'(csr_index))
            vnf_pkg::REG_NOISE_SEED:   seed_ff  <= csr_wdata;
            vnf_pkg::REG_OCTAVE_COUNT: count_ff <= csr_wdata[3:0];
            vnf_pkg::REG_PERSISTENCE:  pers_ff  <= csr_wdata[15:0];
            vnf_pkg::REG_LACUNARITY:   lac_ff   <= csr_wdata[15:0];
            vnf_pkg::REG_HEIGHT_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [vnf_pkg::COUNT_W-1:0] count_eff;
   assign count_eff = (vnf_pkg::COUNT_W'(count_ff) > vnf_pkg::COUNT_W'(MAX_OCTAVES))
                      ? vnf_pkg::COUNT_W'(MAX_OCTAVES) : vnf_pkg::COUNT_W'(count_ff);

   assign busy = 1'b0;

   vnf_pkg::carry_type chain [0:MAX_OCTAVES];

   always_comb begin
      chain[0].valid = start && !busy;
      chain[0].x     = req_noise_x;
      chain[0].z     = req_noise_z;
      chain[0].freq  = vnf_pkg::ONE_Q16;
      chain[0].amp   = vnf_pkg::ONE_Q16;
      chain[0].sum   = '0;
      chain[0].norm  = '0;
   end

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      vnf_octave #(
         .OCT_INDEX (i)
      ) u_octave (
         .clock       (clock),
         .reset       (reset),
         .seed_base   (seed_ff),
         .lacunarity  (lac_ff),
         .persistence (pers_ff),
         .count       (count_eff),
         .carry_in    (chain[i]),
         .carry_out   (chain[i+1])
      );
   end

   logic        dv_valid;
   logic [23:0] dv_quot;

   vnf_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain[MAX_OCTAVES].valid),
      .in_sum    (chain[MAX_OCTAVES].sum),
      .in_norm   (chain[MAX_OCTAVES].norm),
      .out_valid (dv_valid),
      .out_quot  (dv_quot)
   );

   // Height scaling: (2v - 1.0) * scale, floor to Q16.16, saturate.
   logic               h1_valid_ff;
   logic [23:0]        h1_v_ff;
   logic signed [57:0] h1_p_ff;
   logic signed [25:0] tv;

   assign tv = $signed({1'b0, dv_quot, 1'b0}) - 26'sh100_0000;

   always_ff @(posedge clock) begin
      h1_v_ff <= dv_quot;
      h1_p_ff <= 58'(tv * $signed(scale_ff));
      if (reset) begin
         h1_valid_ff <= 1'b0;
      end else begin
         h1_valid_ff <= dv_valid;
      end
   end

   logic signed [33:0] hq;
   logic [31:0]        hsat;

   assign hq = h1_p_ff[57:24];

   always_comb begin
      if ((hq[33:31] == 3'b000) || (hq[33:31] == 3'b111)) begin
         hsat = hq[31:0];
      end else if (hq[33]) begin
         hsat = 32'h8000_0000;
      end else begin
         hsat = 32'h7FFF_FFFF;
      end
   end

   logic        out_valid_ff;
   logic [23:0] out_v_ff;
   logic [31:0] out_h_ff;

   always_ff @(posedge clock) begin
      out_v_ff <= h1_v_ff;
      out_h_ff <= hsat;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= h1_valid_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_unit_value = out_v_ff;
   assign rsp_height     = $signed(out_h_ff);

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      chain[MAX_OCTAVES].valid && (count_eff != '0) |-> chain[MAX_OCTAVES].norm != '0)
      else $error("Amplitude total is zero after at least one octave.");

   a_zero_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_unit_value == 24'd0) && (scale_ff != 32'h8000_0000)
      |-> rsp_height == -$signed(scale_ff))
      else $error("Zero unit value does not give the negated scale.");

   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      dv_valid |=> ##1 rsp_valid)
      else $error("Divider result did not reach the output.");

endmodule
